// ===== design/per_sensor_cascaded_ema_unit_macros.svh =====
// Assertion helpers for the cascaded EMA unit.
// All checks are clocked on aclk and muted while aresetn is low.
`ifndef PER_SENSOR_CASCADED_EMA_UNIT_MACROS_SVH
`define PER_SENSOR_CASCADED_EMA_UNIT_MACROS_SVH

// Same-cycle implication.
`define PSCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("psce: same-cycle check failed");

// Next-cycle implication.
`define PSCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("psce: next-cycle check failed");

`endif

// ===== design/psce_pkg.sv =====
package psce_pkg;

    localparam int NUM_SENSORS = 16;

    localparam int SENSOR_W   = 4;
    localparam int TEMP_IN_W  = 16;
    localparam int HUM_IN_W   = 15;
    localparam int TEMP_OUT_W = 15;
    localparam int HUM_OUT_W  = 10;
    localparam int WEIGHT_W   = 9;
    localparam int CFG_IDX_W  = 2;

    localparam int STAGE_W = 24;            // 1/65536 units
    localparam int DIFF_W  = STAGE_W + 1;   // target - old, or |stage|
    localparam int COEF_W  = 10;            // weight 0..256 or scale 100 / 10, signed
    localparam int PROD_W  = DIFF_W + COEF_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int QUOT_W  = 16;
    localparam int RES_W   = QUOT_W + 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [COEF_W-1:0] SCALE_TEMP = 10'd100;
    localparam logic [COEF_W-1:0] SCALE_HUM  = 10'd10;

    localparam logic signed [RES_W-1:0] TEMP_LO = -17'sd4000;
    localparam logic signed [RES_W-1:0] TEMP_HI = 17'sd12500;
    localparam logic signed [RES_W-1:0] HUM_LO  = 17'sd0;
    localparam logic signed [RES_W-1:0] HUM_HI  = 17'sd1000;

    localparam logic [WEIGHT_W-1:0] RST_TEMP_FAST = 9'd64;
    localparam logic [WEIGHT_W-1:0] RST_TEMP_SLOW = 9'd64;
    localparam logic [WEIGHT_W-1:0] RST_HUM_FAST  = 9'd64;
    localparam logic [WEIGHT_W-1:0] RST_HUM_SLOW  = 9'd192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_FAST = 2'd0,
        CFG_TEMP_SLOW = 2'd1,
        CFG_HUM_FAST  = 2'd2,
        CFG_HUM_SLOW  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } state_t;

    // Sequencer steps: T1 issues a product, H1..SH issue and retire, END retires.
    typedef enum logic [2:0] {
        STEP_T1  = 3'd1,
        STEP_H1  = 3'd2,
        STEP_T2  = 3'd3,
        STEP_H2  = 3'd4,
        STEP_ST  = 3'd5,
        STEP_SH  = 3'd6,
        STEP_END = 3'd7
    } step_t;

    // Weights above 256 act as 256; result is a non-negative signed coefficient.
    function automatic logic signed [COEF_W-1:0] weight_coef(input logic [WEIGHT_W-1:0] w);
        logic [WEIGHT_W-1:0] wc;
        wc = w[WEIGHT_W-1] ? 9'd256 : w;
        return $signed({1'b0, wc});
    endfunction

    // old + floor((w*(target-old) + 128) / 256)
    function automatic logic signed [STAGE_W-1:0] blend_finish(
        input logic signed [STAGE_W-1:0] old,
        input logic signed [PROD_W-1:0]  prod
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] sum;
        acc = ACC_W'(prod) + 36'sd128;
        acc = acc >>> 8;
        sum = ACC_W'(old) + acc;
        return sum[STAGE_W-1:0];
    endfunction

    // (|v|*scale + 32768) / 65536, sign restored afterwards
    function automatic logic signed [RES_W-1:0] scale_finish(
        input logic signed [PROD_W-1:0] prod,
        input logic                     neg
    );
        logic [ACC_W-1:0]         rounded;
        logic signed [RES_W-1:0]  q;
        rounded = ACC_W'(prod) + 36'd32768;
        q = $signed({1'b0, rounded[QUOT_W+15:16]});
        return neg ? -q : q;
    endfunction

endpackage

// ===== design/per_sensor_cascaded_ema_unit.sv =====
// Channel   | Dir | Handshake                | Payload
// ----------+-----+--------------------------+------------------------------------------
// s_        | in  | s_tvalid / s_tready      | s_tdata: sensor_index, temp_sample, hum_sample
// m_        | out | m_tvalid / m_tready      | m_tdata: sensor_echo, temp_filtered, hum_filtered
// cfg_      | in  | cfg_wr_en (no back-press)| cfg_index, cfg_wdata (9-bit weights)
//
// Per item: accept, stage fetch, seven sequencer steps, result write; the next item waits for idle.
// A single 25x10 signed multiplier serves four blends and two output scalings in turn,
// each product registered before it is used. Reset (aresetn low, synchronous) clears
// control and seen flags and sets weights to defaults; stage store is kept, unseen sensors load.
// s_tready is high only while idle; a result waiting in the m_ register does not block
// the next transfer, only that item's own write-out waits for m_tready.
module per_sensor_cascaded_ema_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] sensor_index, [19:4] temp_sample, [34:20] hum_sample, [39:35] zero
    input  logic [psce_pkg::S_TDATA_W-1:0]      s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] sensor_echo, [18:4] temp_filtered, [28:19] hum_filtered, [31:29] zero
    output logic [psce_pkg::M_TDATA_W-1:0]      m_tdata,

    input  logic                                cfg_wr_en,
    input  logic [psce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psce_pkg::WEIGHT_W-1:0]       cfg_wdata
);

    localparam int SW = psce_pkg::STAGE_W;

    // ---------------------------------------------------------------- weights
    logic [psce_pkg::WEIGHT_W-1:0] w_temp_fast_reg, w_temp_slow_reg;
    logic [psce_pkg::WEIGHT_W-1:0] w_hum_fast_reg,  w_hum_slow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_temp_fast_reg <= psce_pkg::RST_TEMP_FAST;
            w_temp_slow_reg <= psce_pkg::RST_TEMP_SLOW;
            w_hum_fast_reg  <= psce_pkg::RST_HUM_FAST;
            w_hum_slow_reg  <= psce_pkg::RST_HUM_SLOW;
        end else if (cfg_wr_en) begin
            unique case (psce_pkg::cfg_index_t'(cfg_index))
                psce_pkg::CFG_TEMP_FAST: w_temp_fast_reg <= cfg_wdata;
                psce_pkg::CFG_TEMP_SLOW: w_temp_slow_reg <= cfg_wdata;
                psce_pkg::CFG_HUM_FAST:  w_hum_fast_reg  <= cfg_wdata;
                psce_pkg::CFG_HUM_SLOW:  w_hum_slow_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input fields
    logic [psce_pkg::SENSOR_W-1:0]  s_idx;
    logic [psce_pkg::TEMP_IN_W-1:0] s_temp;
    logic [psce_pkg::HUM_IN_W-1:0]  s_hum;
    logic                           s_xfer;
    logic                           s_in_range;

    assign s_idx      = s_tdata[3:0];
    assign s_temp     = s_tdata[19:4];
    assign s_hum      = s_tdata[34:20];
    assign s_xfer     = s_tvalid && s_tready;
    assign s_in_range = 32'(s_idx) < psce_pkg::NUM_SENSORS;

    // ---------------------------------------------------------------- state
    psce_pkg::state_t state_reg, state_next;
    psce_pkg::step_t  step_reg,  step_next;

    logic [psce_pkg::SENSOR_W-1:0]  idx_reg;
    logic [psce_pkg::TEMP_IN_W-1:0] temp_raw_reg;
    logic [psce_pkg::HUM_IN_W-1:0]  hum_raw_reg;
    logic                           in_range_reg;
    logic                           seen_hit_reg;

    logic signed [SW-1:0] t1_reg, t1_next, t2_reg, t2_next;
    logic signed [SW-1:0] h1_reg, h1_next, h2_reg, h2_next;
    logic signed [psce_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [psce_pkg::TEMP_OUT_W-1:0] tq_reg, tq_next;
    logic [psce_pkg::HUM_OUT_W-1:0]         hq_reg, hq_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [psce_pkg::M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    logic seen_reg [psce_pkg::NUM_SENSORS];
    logic [4*SW-1:0] stage_mem [psce_pkg::NUM_SENSORS];
    logic [4*SW-1:0] rd_reg;
    logic            mem_we;

    // raw samples scaled to stage units
    logic signed [SW-1:0] tx, hx;
    assign tx = $signed({temp_raw_reg, 8'h00});
    assign hx = $signed({1'b0, hum_raw_reg, 8'h00});

    // ---------------------------------------------------------------- stage store
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            rd_reg <= stage_mem[s_idx];
        end
        if (mem_we) begin
            stage_mem[idx_reg] <= {t1_reg, t2_reg, h1_reg, h2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < psce_pkg::NUM_SENSORS; i++) begin
                seen_reg[i] <= 1'b0;
            end
        end else if (mem_we) begin
            seen_reg[idx_reg] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- shared multiplier
    logic signed [psce_pkg::DIFF_W-1:0] mul_a;
    logic signed [psce_pkg::COEF_W-1:0] mul_b;
    logic signed [psce_pkg::RES_W-1:0]  tq_full, hq_full;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            psce_pkg::STEP_T1: begin
                mul_a = psce_pkg::DIFF_W'(tx) - psce_pkg::DIFF_W'(t1_reg);
                mul_b = psce_pkg::weight_coef(w_temp_fast_reg);
            end
            psce_pkg::STEP_H1: begin
                mul_a = psce_pkg::DIFF_W'(hx) - psce_pkg::DIFF_W'(h1_reg);
                mul_b = psce_pkg::weight_coef(w_hum_fast_reg);
            end
            psce_pkg::STEP_T2: begin
                mul_a = psce_pkg::DIFF_W'(t1_reg) - psce_pkg::DIFF_W'(t2_reg);
                mul_b = psce_pkg::weight_coef(w_temp_slow_reg);
            end
            psce_pkg::STEP_H2: begin
                mul_a = psce_pkg::DIFF_W'(h1_reg) - psce_pkg::DIFF_W'(h2_reg);
                mul_b = psce_pkg::weight_coef(w_hum_slow_reg);
            end
            psce_pkg::STEP_ST: begin
                // magnitude; -2^23 still fits in 25 signed bits
                mul_a = t2_reg[SW-1] ? -psce_pkg::DIFF_W'(t2_reg) : psce_pkg::DIFF_W'(t2_reg);
                mul_b = $signed(psce_pkg::SCALE_TEMP);
            end
            psce_pkg::STEP_SH: begin
                mul_a = h2_reg[SW-1] ? -psce_pkg::DIFF_W'(h2_reg) : psce_pkg::DIFF_W'(h2_reg);
                mul_b = $signed(psce_pkg::SCALE_HUM);
            end
            default: ;
        endcase
    end

    assign tq_full = psce_pkg::scale_finish(prod_reg, t2_reg[SW-1]);
    assign hq_full = psce_pkg::scale_finish(prod_reg, h2_reg[SW-1]);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        h1_next       = h1_reg;
        h2_next       = h2_reg;
        prod_next     = mul_a * mul_b;
        tq_next       = tq_reg;
        hq_next       = hq_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        s_tready      = 1'b0;

        unique case (state_reg)
            psce_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = psce_pkg::ST_LOAD;
                end
            end
            psce_pkg::ST_LOAD: begin
                // unseen sensor: stages start at the sample, so the blends are identities
                if (seen_hit_reg) begin
                    t1_next = $signed(rd_reg[4*SW-1:3*SW]);
                    t2_next = $signed(rd_reg[3*SW-1:2*SW]);
                    h1_next = $signed(rd_reg[2*SW-1:SW]);
                    h2_next = $signed(rd_reg[SW-1:0]);
                end else begin
                    t1_next = tx;
                    t2_next = tx;
                    h1_next = hx;
                    h2_next = hx;
                end
                step_next  = psce_pkg::STEP_T1;
                state_next = psce_pkg::ST_RUN;
            end
            psce_pkg::ST_RUN: begin
                unique case (step_reg)
                    psce_pkg::STEP_T1: begin
                        step_next = psce_pkg::STEP_H1;
                    end
                    psce_pkg::STEP_H1: begin
                        t1_next   = psce_pkg::blend_finish(t1_reg, prod_reg);
                        step_next = psce_pkg::STEP_T2;
                    end
                    psce_pkg::STEP_T2: begin
                        h1_next   = psce_pkg::blend_finish(h1_reg, prod_reg);
                        step_next = psce_pkg::STEP_H2;
                    end
                    psce_pkg::STEP_H2: begin
                        t2_next   = psce_pkg::blend_finish(t2_reg, prod_reg);
                        step_next = psce_pkg::STEP_ST;
                    end
                    psce_pkg::STEP_ST: begin
                        h2_next   = psce_pkg::blend_finish(h2_reg, prod_reg);
                        step_next = psce_pkg::STEP_SH;
                    end
                    psce_pkg::STEP_SH: begin
                        priority if (tq_full < psce_pkg::TEMP_LO) begin
                            tq_next = psce_pkg::TEMP_LO[psce_pkg::TEMP_OUT_W-1:0];
                        end else if (tq_full > psce_pkg::TEMP_HI) begin
                            tq_next = psce_pkg::TEMP_HI[psce_pkg::TEMP_OUT_W-1:0];
                        end else begin
                            tq_next = tq_full[psce_pkg::TEMP_OUT_W-1:0];
                        end
                        step_next = psce_pkg::STEP_END;
                    end
                    psce_pkg::STEP_END: begin
                        priority if (hq_full < psce_pkg::HUM_LO) begin
                            hq_next = psce_pkg::HUM_LO[psce_pkg::HUM_OUT_W-1:0];
                        end else if (hq_full > psce_pkg::HUM_HI) begin
                            hq_next = psce_pkg::HUM_HI[psce_pkg::HUM_OUT_W-1:0];
                        end else begin
                            hq_next = hq_full[psce_pkg::HUM_OUT_W-1:0];
                        end
                        state_next = psce_pkg::ST_DONE;
                    end
                    default: begin
                        state_next = psce_pkg::ST_IDLE;
                    end
                endcase
            end
            psce_pkg::ST_DONE: begin
                // output register free or being emptied this cycle
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, hq_reg, tq_reg, idx_reg};
                    mem_we        = in_range_reg;
                    state_next    = psce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psce_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= psce_pkg::ST_IDLE;
            step_reg     <= psce_pkg::STEP_T1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            idx_reg      <= s_idx;
            temp_raw_reg <= s_temp;
            hum_raw_reg  <= s_hum;
            in_range_reg <= s_in_range;
            seen_hit_reg <= s_in_range && seen_reg[s_idx];
        end
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        h1_reg      <= h1_next;
        h2_reg      <= h2_next;
        prod_reg    <= prod_next;
        tq_reg      <= tq_next;
        hq_reg      <= hq_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- checks
`include "per_sensor_cascaded_ema_unit_macros.svh"

    // s_tready drops once a transfer is taken
    `PSCE_ASSERT_NEXT(a_busy_after_xfer, s_xfer, !s_tready)
    // a fresh result only comes out of the write-out state
    `PSCE_ASSERT_NOW(a_result_from_done, $rose(m_tvalid), $past(state_reg) == psce_pkg::ST_DONE)
    // write-out with an empty output register never stalls
    `PSCE_ASSERT_NEXT(a_done_empty_slot, state_reg == psce_pkg::ST_DONE && !m_tvalid_reg,
        m_tvalid_reg && state_reg == psce_pkg::ST_IDLE)

endmodule
